@@ rtl/core/ilv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilv_pkg
// Shared constants, codes and control types of the integer list validator.
// ----------------------------------------------------------------------------
package ilv_pkg;

	localparam int MAX_VALUES = 512;
	localparam int IDX_W      = $clog2(MAX_VALUES);
	localparam int CNT_W      = $clog2(MAX_VALUES + 1);
	localparam int VALUE_W    = 32;
	localparam int COUNT_W    = 10;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_ONE   = 8'd49;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_PLUS  = 8'd43;

	typedef enum logic [1:0] {
		CMD_CHAR     = 2'd0,
		CMD_END_ARG  = 2'd1,
		CMD_END_LIST = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_SYNTAX = 3'd2,
		ST_RANGE  = 3'd3,
		ST_DUP    = 3'd4,
		ST_FULL   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_SIGN  = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	typedef enum logic [0:0] {
		KIND_ARG  = 1'b0,
		KIND_LIST = 1'b1
	} kind_t;

	typedef struct packed {
		logic take_char;
		logic end_arg;
		logic end_list;
		logic scan;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic scan_done;
	} dp_stat_t;

endpackage

@@ rtl/core/ilv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ilv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/ilv_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilv_ctrl
// Controller: input handshake, command decode and duplicate-scan sequencing.
// ----------------------------------------------------------------------------
module ilv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        command,
	input  ilv_pkg::dp_stat_t stat,
	output ilv_pkg::dp_cmd_t  cmd
);

	ilv_pkg::state_t state_q;
	ilv_pkg::state_t state_d;
	logic            accept;

	assign in_ready = (state_q == ilv_pkg::S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilv_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ilv_pkg::S_IDLE: begin
				if (accept && (ilv_pkg::cmd_t'(command) == ilv_pkg::CMD_END_ARG)) begin
					state_d = ilv_pkg::S_SCAN;
				end
			end
			ilv_pkg::S_SCAN: begin
				if (stat.scan_done) begin
					state_d = ilv_pkg::S_IDLE;
				end
			end
			default: state_d = ilv_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ilv_pkg::S_IDLE: begin
				if (accept) begin
					unique case (ilv_pkg::cmd_t'(command))
						ilv_pkg::CMD_CHAR:     cmd.take_char = 1'b1;
						ilv_pkg::CMD_END_ARG:  cmd.end_arg   = 1'b1;
						ilv_pkg::CMD_END_LIST: cmd.end_list  = 1'b1;
						default: ;
					endcase
				end
			end
			ilv_pkg::S_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.finish = stat.scan_done;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_scan_output_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ilv_pkg::S_SCAN |-> stat.out_free)
		else $error("scan running while a result is pending");
	a_finish_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ilv_pkg::S_IDLE)
		else $error("controller did not return to idle after finish");
	a_end_arg_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_arg |=> state_q == ilv_pkg::S_SCAN)
		else $error("end of argument did not start a scan");
`endif

endmodule

@@ rtl/core/ilv_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilv_dp
// Datapath: digit accumulator, argument checks, seen-value table walk and
// output register.
// ----------------------------------------------------------------------------
module ilv_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ilv_pkg::dp_cmd_t                     cmd,
	output ilv_pkg::dp_stat_t                    stat,
	input  logic [7:0]                           ch,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic                                 result_kind,
	output logic signed [ilv_pkg::VALUE_W-1:0]   value,
	output logic [2:0]                           status,
	output logic [ilv_pkg::COUNT_W-1:0]          count,
	output logic                                 list_error
);

	// argument accumulator
	logic [ilv_pkg::VALUE_W-1:0] mag_q, mag_d;
	logic                        neg_q, neg_d;
	ilv_pkg::phase_t             phase_q, phase_d;
	logic                        syn_q, syn_d;
	logic                        ovf_q, ovf_d;

	// list state
	logic [ilv_pkg::CNT_W-1:0]   cnt_q;
	logic                        sticky_q;

	// latched argument under check
	logic [ilv_pkg::VALUE_W-1:0] val_q;
	ilv_pkg::status_t            pre_q;
	logic [ilv_pkg::CNT_W-1:0]   idx_q;
	logic                        pend_q;

	// output register
	logic                        out_valid_q;
	logic                        kind_q;
	logic [ilv_pkg::VALUE_W-1:0] value_q;
	logic [2:0]                  status_q;
	logic [ilv_pkg::COUNT_W-1:0] count_q;
	logic                        lerr_q;

	logic                        digit;
	logic [3:0]                  dval;
	logic [ilv_pkg::VALUE_W+3:0] prod;
	ilv_pkg::status_t            pre_st;
	logic [ilv_pkg::VALUE_W-1:0] arg_val;
	logic [ilv_pkg::VALUE_W-1:0] rd_data;
	logic                        more;
	logic                        issue;
	logic                        hit;
	logic                        full;
	ilv_pkg::status_t            fin_st;
	logic                        fin_ok;
	logic                        we;

	assign digit = (ch >= ilv_pkg::CH_ZERO) && (ch <= ilv_pkg::CH_NINE);
	assign dval  = 4'(ch - ilv_pkg::CH_ZERO);
	assign prod  = ((ilv_pkg::VALUE_W+4)'(mag_q) << 3) + ((ilv_pkg::VALUE_W+4)'(mag_q) << 1)
		+ (ilv_pkg::VALUE_W+4)'(dval);

	always_comb begin
		mag_d   = mag_q;
		neg_d   = neg_q;
		phase_d = phase_q;
		syn_d   = syn_q;
		ovf_d   = ovf_q;
		if (phase_q == ilv_pkg::PH_START
			&& (ch == ilv_pkg::CH_MINUS || ch == ilv_pkg::CH_PLUS)) begin
			neg_d   = (ch == ilv_pkg::CH_MINUS);
			phase_d = ilv_pkg::PH_SIGN;
		end else begin
			if (phase_q == ilv_pkg::PH_SIGN && (ch < ilv_pkg::CH_ONE || ch > ilv_pkg::CH_NINE)) begin
				syn_d = 1'b1;
			end
			if (digit) begin
				if (prod > (ilv_pkg::VALUE_W+4)'(36'h0_8000_0000)) begin
					ovf_d = 1'b1;
				end
				if (prod[ilv_pkg::VALUE_W+3:ilv_pkg::VALUE_W] != 4'd0) begin
					mag_d = '1;
				end else begin
					mag_d = prod[ilv_pkg::VALUE_W-1:0];
				end
			end else begin
				syn_d = 1'b1;
			end
			phase_d = ilv_pkg::PH_BODY;
		end
	end

	always_comb begin
		if (phase_q == ilv_pkg::PH_START) begin
			pre_st = ilv_pkg::ST_EMPTY;
		end else if (syn_q || phase_q == ilv_pkg::PH_SIGN) begin
			pre_st = ilv_pkg::ST_SYNTAX;
		end else if (ovf_q || (!neg_q && mag_q[ilv_pkg::VALUE_W-1])) begin
			pre_st = ilv_pkg::ST_RANGE;
		end else begin
			pre_st = ilv_pkg::ST_OK;
		end
	end

	assign arg_val = neg_q ? (~mag_q + 1'b1) : mag_q;

	// table walk: one read issued per cycle, compared in the cycle after
	assign hit   = pend_q && (rd_data == val_q);
	assign more  = (pre_q == ilv_pkg::ST_OK) && (idx_q < cnt_q);
	assign issue = cmd.scan && more && !hit;
	assign full  = (cnt_q >= ilv_pkg::CNT_W'(ilv_pkg::MAX_VALUES));

	always_comb begin
		if (pre_q != ilv_pkg::ST_OK) begin
			fin_st = pre_q;
		end else if (hit) begin
			fin_st = ilv_pkg::ST_DUP;
		end else if (full) begin
			fin_st = ilv_pkg::ST_FULL;
		end else begin
			fin_st = ilv_pkg::ST_OK;
		end
	end

	assign fin_ok = (fin_st == ilv_pkg::ST_OK);
	assign we     = cmd.finish && fin_ok;

	assign stat.scan_done = hit || (!more && !pend_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	ilv_ram #(
		.WIDTH (ilv_pkg::VALUE_W),
		.DEPTH (ilv_pkg::MAX_VALUES)
	) u_seen (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ilv_pkg::IDX_W-1:0]),
		.wdata (val_q),
		.raddr (idx_q[ilv_pkg::IDX_W-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q    <= '0;
			neg_q    <= 1'b0;
			phase_q  <= ilv_pkg::PH_START;
			syn_q    <= 1'b0;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
			sticky_q <= 1'b0;
			idx_q    <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (cmd.take_char) begin
				mag_q   <= mag_d;
				neg_q   <= neg_d;
				phase_q <= phase_d;
				syn_q   <= syn_d;
				ovf_q   <= ovf_d;
			end else if (cmd.end_arg || cmd.end_list) begin
				mag_q   <= '0;
				neg_q   <= 1'b0;
				phase_q <= ilv_pkg::PH_START;
				syn_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end
			if (cmd.end_arg) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (cmd.scan) begin
				pend_q <= issue;
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.end_list) begin
				cnt_q    <= '0;
				sticky_q <= 1'b0;
			end else if (cmd.finish) begin
				if (fin_ok) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					sticky_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.end_arg) begin
			val_q <= arg_val;
			pre_q <= pre_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish || cmd.end_list) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			kind_q   <= ilv_pkg::KIND_ARG;
			value_q  <= fin_ok ? val_q : '0;
			status_q <= fin_st;
			count_q  <= ilv_pkg::COUNT_W'(cnt_q + ilv_pkg::CNT_W'(fin_ok));
			lerr_q   <= sticky_q || !fin_ok;
		end else if (cmd.end_list) begin
			kind_q   <= ilv_pkg::KIND_LIST;
			value_q  <= '0;
			status_q <= ilv_pkg::ST_OK;
			count_q  <= ilv_pkg::COUNT_W'(cnt_q);
			lerr_q   <= sticky_q || (phase_q != ilv_pkg::PH_START);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign value       = value_q;
	assign status      = status_q;
	assign count       = count_q;
	assign list_error  = lerr_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ilv_pkg::CNT_W'(ilv_pkg::MAX_VALUES))
		else $error("seen count beyond table depth");
	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> !full)
		else $error("table write while full");
	a_fail_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ilv_pkg::ST_OK |-> value_q == '0 && lerr_q)
		else $error("failed argument reported a value or no list error");
	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.end_list |=> cnt_q == '0 && !sticky_q && phase_q == ilv_pkg::PH_START)
		else $error("list state not cleared after summary");
`endif

endmodule

@@ rtl/core/integer_list_validator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_list_validator
// Checks a list of decimal arguments fed one character per beat and flags
// empty, malformed, out-of-range, duplicate and table-full arguments.
// ----------------------------------------------------------------------------
// An end-of-argument beat holds the input while the duplicate scan runs; the
// scan reads no entries when the table is empty or the argument has already
// failed a syntax or range check. Otherwise the duplicate check walks the
// seen-value table through its single registered read port, one entry a
// cycle, and the walk stops early on a match. An end-of-list beat empties the
// table. Each result is held in an output register. The input stalls while a
// result is waiting or while the scan is running.
module integer_list_validator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          command,
	input  logic [7:0]                          ch,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                result_kind,
	output logic signed [ilv_pkg::VALUE_W-1:0]  value,
	output logic [2:0]                          status,
	output logic [ilv_pkg::COUNT_W-1:0]         count,
	output logic                                list_error
);

	ilv_pkg::dp_cmd_t  dp_cmd;
	ilv_pkg::dp_stat_t dp_stat;

	ilv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	ilv_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.ch          (ch),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.value       (value),
		.status      (status),
		.count       (count),
		.list_error  (list_error)
	);

endmodule

@@ tb/sv/tb_integer_list_validator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_list_validator
// Self-checking bench for the integer list validator. A short scripted list
// covers empty, signed, malformed, duplicate and unfinished arguments, then
// random lists of mostly well-formed numbers with noise follow. Every result
// beat is checked field by field against the script's expected values or an
// in-bench model, with random idling on both sides until the last part.
// ----------------------------------------------------------------------------
module tb_integer_list_validator;
	import ilv_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         RANDOM_BEATS = 1275;
	localparam int         QUIET_BEATS  = 200;
	localparam int         SCRIPT_BEATS = 25;

	typedef struct {
		kind_t              kind;
		logic signed [31:0] value;
		status_t            status;
		logic [9:0]         count;
		logic               err;
	} report_t;

	typedef struct {
		logic [1:0] cmd;
		logic [7:0] c;
		bit         typed;
		report_t    rep;
	} script_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [1:0]                command  = CMD_CHAR;
	logic [7:0]                ch       = 8'h00;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      result_kind;
	logic signed [VALUE_W-1:0] value;
	logic [2:0]                status;
	logic [COUNT_W-1:0]        count;
	logic                      list_error;

	// parser model state
	logic [31:0]  acc_mag;
	bit           acc_neg;
	phase_t       acc_phase;
	bit           acc_bad;
	bit           acc_ovf;
	logic [31:0]  stored_vals[$];
	bit           list_flag;

	report_t      awaited_reports[$];
	report_t      blank_report;
	script_row_t  script[$];
	logic [7:0]   arg_text[$];
	int           failures   = 0;
	int           beats_sent = 0;
	int           stall_left = 0;
	bit           quiet        = 1'b0;
	bit           src_idle_en  = 1'b1;
	bit           sink_idle_en = 1'b1;

	integer_list_validator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.value       (value),
		.status      (status),
		.count       (count),
		.list_error  (list_error)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_integer_list_validator: FAIL");
		$finish;
	end

	function automatic void clear_arg();
		acc_mag   = 32'd0;
		acc_neg   = 1'b0;
		acc_phase = PH_START;
		acc_bad   = 1'b0;
		acc_ovf   = 1'b0;
	endfunction

	function automatic void parse_beat(input logic [1:0] cmd, input logic [7:0] c,
			output bit has, output report_t rep);
		logic [63:0] prod;
		bit          is_digit;
		bit          dup;
		status_t     st;
		logic [31:0] v;
		has      = 1'b0;
		rep      = blank_report;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		case (cmd)
			CMD_CHAR: begin
				if (acc_phase == PH_START && (c == CH_MINUS || c == CH_PLUS)) begin
					acc_neg   = (c == CH_MINUS);
					acc_phase = PH_SIGN;
				end else begin
					if (acc_phase == PH_SIGN && (c < CH_ONE || c > CH_NINE))
						acc_bad = 1'b1;
					if (is_digit) begin
						prod = {32'd0, acc_mag} * 64'd10 + {56'd0, c - CH_ZERO};
						if (prod > 64'h8000_0000)
							acc_ovf = 1'b1;
						if (prod > 64'hFFFF_FFFF)
							prod = 64'hFFFF_FFFF;
						acc_mag = prod[31:0];
					end else begin
						acc_bad = 1'b1;
					end
					acc_phase = PH_BODY;
				end
			end
			CMD_END_ARG: begin
				st  = ST_OK;
				v   = 32'd0;
				dup = 1'b0;
				if (acc_phase == PH_START) begin
					st = ST_EMPTY;
				end else if (acc_bad || acc_phase == PH_SIGN) begin
					st = ST_SYNTAX;
				end else if (acc_ovf || (!acc_neg && acc_mag > 32'h7FFF_FFFF)) begin
					st = ST_RANGE;
				end else begin
					v = acc_neg ? (32'd0 - acc_mag) : acc_mag;
					foreach (stored_vals[i])
						if (stored_vals[i] == v)
							dup = 1'b1;
					if (dup)
						st = ST_DUP;
					else if (stored_vals.size() >= MAX_VALUES)
						st = ST_FULL;
					else
						stored_vals.push_back(v);
				end
				if (st != ST_OK) begin
					v         = 32'd0;
					list_flag = 1'b1;
				end
				clear_arg();
				has        = 1'b1;
				rep.kind   = KIND_ARG;
				rep.value  = v;
				rep.status = st;
				rep.count  = 10'(stored_vals.size());
				rep.err    = list_flag;
			end
			CMD_END_LIST: begin
				if (acc_phase != PH_START)
					list_flag = 1'b1;
				clear_arg();
				has        = 1'b1;
				rep.kind   = KIND_LIST;
				rep.value  = 32'sd0;
				rep.status = ST_OK;
				rep.count  = 10'(stored_vals.size());
				rep.err    = list_flag;
				stored_vals.delete();
				list_flag = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_beat(input logic [1:0] cmd, input logic [7:0] c, input bit typed,
			input report_t typed_rep);
		bit      has;
		report_t rep;
		if (src_idle_en && !quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		ch       <= c;
		do @(posedge clk); while (!in_ready);
		parse_beat(cmd, c, has, rep);
		if (has)
			awaited_reports.push_back(typed ? typed_rep : rep);
		if (cmd != CMD_UNUSED)
			beats_sent++;
	endtask

	task automatic send_plain(input logic [1:0] cmd, input logic [7:0] c);
		send_beat(cmd, c, 1'b0, blank_report);
	endtask

	task automatic send_text();
		foreach (arg_text[i]) begin
			if ($urandom_range(0, 40) == 0)
				send_plain(CMD_UNUSED, 8'($urandom));
			send_plain(CMD_CHAR, arg_text[i]);
		end
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic void add_row(input logic [1:0] cmd, input logic [7:0] c);
		script_row_t r;
		r.cmd   = cmd;
		r.c     = c;
		r.typed = 1'b0;
		r.rep   = blank_report;
		script.push_back(r);
	endfunction

	function automatic void add_checked(input logic [1:0] cmd, input kind_t kind, input int val,
			input status_t st, input int cnt, input bit err);
		script_row_t r;
		r.cmd        = cmd;
		r.c          = 8'h00;
		r.typed      = 1'b1;
		r.rep.kind   = kind;
		r.rep.value  = val;
		r.rep.status = st;
		r.rep.count  = 10'(cnt);
		r.rep.err    = err;
		script.push_back(r);
	endfunction

	function automatic void compose_number(input longint unsigned mag, input bit neg,
			input bit plus, input int zeros);
		longint unsigned rest;
		logic [7:0]      digits[$];
		rest = mag;
		arg_text.delete();
		if (neg)
			arg_text.push_back(CH_MINUS);
		else if (plus)
			arg_text.push_back(CH_PLUS);
		repeat (zeros) arg_text.push_back(CH_ZERO);
		if (rest == 0)
			digits.push_back(CH_ZERO);
		while (rest != 0) begin
			digits.push_front(CH_ZERO + 8'(rest % 10));
			rest = rest / 10;
		end
		foreach (digits[i])
			arg_text.push_back(digits[i]);
	endfunction

	function automatic void compose_well_formed();
		longint unsigned mag;
		bit              neg;
		bit              plus;
		int              zeros;
		neg = $urandom_range(0, 1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mag = $urandom_range(0, 40);
			4, 5:       mag = 64'($urandom >> 1);
			6: begin
				case ($urandom_range(0, 4))
					0:       mag = 64'd0;
					1:       mag = 64'h7FFF_FFFF;
					2:       mag = 64'h8000_0000;
					3:       mag = 64'h8000_0001;
					default: mag = 64'hFFFF_FFFF + 64'($urandom_range(0, 1));
				endcase
			end
			7:       mag = 64'($urandom) | (64'd1 << $urandom_range(32, 63));
			default: mag = $urandom_range(0, 99999);
		endcase
		if (mag == 0)
			neg = 1'b0;
		plus  = !neg && mag != 0 && $urandom_range(0, 3) == 0;
		zeros = (!neg && !plus && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
		compose_number(mag, neg, plus, zeros);
	endfunction

	function automatic void compose_noise();
		int len;
		int r;
		len = $urandom_range(0, 8);
		arg_text.delete();
		repeat (len) begin
			r = $urandom_range(0, 19);
			if (r < 10)
				arg_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			else if (r < 12)
				arg_text.push_back(CH_MINUS);
			else if (r < 13)
				arg_text.push_back(CH_PLUS);
			else
				arg_text.push_back(8'($urandom));
		end
	endfunction

	task automatic run_random_list();
		int n_args;
		src_idle_en  = $urandom_range(0, 4) != 0;
		sink_idle_en = $urandom_range(0, 4) != 0;
		n_args = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
		for (int a = 0; a < n_args; a++) begin
			if ($urandom_range(0, 9) < 7)
				compose_well_formed();
			else
				compose_noise();
			send_text();
			// sometimes leave the last argument open at end of list
			if (!(a == n_args - 1 && $urandom_range(0, 7) == 0))
				send_plain(CMD_END_ARG, 8'($urandom));
		end
		send_plain(CMD_END_LIST, 8'($urandom));
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// output sink with bursty stalls
	initial begin
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && sink_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				$display("%0t: unexpected result beat, expected none,", $time,
					" actual kind %0d value %0d status %0d",
					result_kind, value, status);
				failures++;
			end else begin
				want = awaited_reports.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("value", want.value, value);
				check_field("status", want.status, status);
				check_field("count", want.count, count);
				check_field("list_error", want.err, list_error);
			end
		end
	end

	initial begin
		blank_report.kind   = KIND_ARG;
		blank_report.value  = 32'sd0;
		blank_report.status = ST_OK;
		blank_report.count  = 10'd0;
		blank_report.err    = 1'b0;
		clear_arg();
		stored_vals.delete();
		list_flag = 1'b0;

		add_checked(CMD_END_ARG, KIND_ARG, 0, ST_EMPTY, 0, 1'b1);
		add_row(CMD_UNUSED, 8'hFF);
		add_checked(CMD_END_LIST, KIND_LIST, 0, ST_OK, 0, 1'b1);
		add_row(CMD_CHAR, CH_ZERO);
		add_row(CMD_CHAR, CH_ZERO);
		add_row(CMD_CHAR, CH_ZERO + 8'd7);
		add_checked(CMD_END_ARG, KIND_ARG, 7, ST_OK, 1, 1'b0);
		add_row(CMD_CHAR, CH_ZERO + 8'd7);
		add_checked(CMD_END_ARG, KIND_ARG, 0, ST_DUP, 1, 1'b1);
		add_row(CMD_CHAR, CH_MINUS);
		add_row(CMD_CHAR, CH_ZERO);
		add_checked(CMD_END_ARG, KIND_ARG, 0, ST_SYNTAX, 1, 1'b1);
		add_row(CMD_CHAR, CH_PLUS);
		add_checked(CMD_END_ARG, KIND_ARG, 0, ST_SYNTAX, 1, 1'b1);
		add_row(CMD_CHAR, CH_ZERO + 8'd5);
		add_row(CMD_CHAR, CH_MINUS);
		add_checked(CMD_END_ARG, KIND_ARG, 0, ST_SYNTAX, 1, 1'b1);
		add_row(CMD_CHAR, 8'h00);
		add_checked(CMD_END_ARG, KIND_ARG, 0, ST_SYNTAX, 1, 1'b1);
		add_row(CMD_CHAR, CH_MINUS);
		add_row(CMD_CHAR, CH_NINE);
		add_checked(CMD_END_ARG, KIND_ARG, -9, ST_OK, 2, 1'b1);
		add_checked(CMD_END_LIST, KIND_LIST, 0, ST_OK, 2, 1'b1);
		add_row(CMD_CHAR, 8'hFF);
		add_checked(CMD_END_LIST, KIND_LIST, 0, ST_OK, 0, 1'b1);

		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_beat(script[i].cmd, script[i].c, script[i].typed, script[i].rep);
		pause_until_drained();

		while (beats_sent < SCRIPT_BEATS + RANDOM_BEATS) begin
			// no idling on either side in the last part
			if (beats_sent >= SCRIPT_BEATS + RANDOM_BEATS - QUIET_BEATS)
				quiet = 1'b1;
			run_random_list();
			if (!quiet && $urandom_range(0, 11) == 0)
				pause_until_drained();
		end

		pause_until_drained();
		repeat (50) @(posedge clk);
		if (failures == 0)
			$display("tb_integer_list_validator: PASS");
		else
			$display("tb_integer_list_validator: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ilv_pkg.sv
rtl/core/ilv_ram.sv
rtl/core/ilv_ctrl.sv
rtl/core/ilv_dp.sv
rtl/core/integer_list_validator.sv
tb/sv/tb_integer_list_validator.sv
